// ===== sv/shrb_pkg.sv =====
// Package for the stereo history ring buffer: constants, codes, interface types, sample formatter
package shrb_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int SAMPLE_W  = 16;
	localparam int CNT_W     = 7;
	localparam int OP_W      = 2;
	localparam int MODE_W    = 2;

	localparam logic [OP_W-1:0] OP_WRITE_STEREO = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE_MONO   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ         = 2'd2;

	localparam logic [MODE_W-1:0] MODE_Q15  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_S8   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_U8   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PEEK = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic write_en;
		logic mono;
		logic read_start;
		logic issue;
	} shrb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic count_zero;
		logic last_issue;
	} shrb_status_t;

	// Q1.15 to the requested output format; 8-bit forms truncate toward zero
	// (their clamps can never act, so none is built)
	function automatic logic [SAMPLE_W-1:0] fmt_sample(logic [MODE_W-1:0] mode,
			logic signed [SAMPLE_W-1:0] s);
		logic signed [23:0] p;
		logic signed [23:0] t;
		logic [23:0]        u;
		logic [SAMPLE_W-1:0] r;
		p = s * 24'sd127;
		t = (p + ((p < 0) ? 24'sd32767 : 24'sd0)) >>> 15;
		u = 24'(p + 24'sd4194304);
		unique case (mode)
			MODE_S8: r = t[SAMPLE_W-1:0];
			MODE_U8: r = {8'd0, u[22:15]};
			default: r = s;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/shrb_ctrl.sv =====
// Controller state machine: command decode and read burst sequencing
module shrb_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [shrb_pkg::OP_W-1:0]   operation,
	input  shrb_pkg::shrb_status_t      status,
	output shrb_pkg::shrb_cmd_t         cmd,
	output logic                        busy
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		cmd.write_en   = accept && (operation == shrb_pkg::OP_WRITE_STEREO ||
			operation == shrb_pkg::OP_WRITE_MONO);
		cmd.mono       = (operation == shrb_pkg::OP_WRITE_MONO);
		cmd.read_start = accept && (operation == shrb_pkg::OP_READ);
		cmd.issue      = (state_q == ST_ISSUE);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.read_start && !status.count_zero)
					state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (status.last_issue)
					state_d = ST_FLUSH;
			end
			// the flush state lets the final store read land before returning to idle
			ST_FLUSH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_issue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE && !status.last_issue) |=> state_q == ST_ISSUE)
		else $error("burst ended early");

endmodule

// ===== sv/shrb_datapath.sv =====
// Datapath: sample store, pointers, fresh mark, burst address counter, output format
module shrb_datapath #(
	parameter int DEPTH = shrb_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  shrb_pkg::shrb_cmd_t                 cmd,
	output shrb_pkg::shrb_status_t              status,
	input  logic signed [shrb_pkg::SAMPLE_W-1:0] left_sample,
	input  logic signed [shrb_pkg::SAMPLE_W-1:0] right_sample,
	input  logic [shrb_pkg::CNT_W-1:0]          read_count,
	input  logic [shrb_pkg::MODE_W-1:0]         read_mode,
	output logic                                done,
	output logic signed [shrb_pkg::SAMPLE_W-1:0] out_left,
	output logic signed [shrb_pkg::SAMPLE_W-1:0] out_right,
	output logic [shrb_pkg::CNT_W-1:0]          fresh_count,
	output logic                                last
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int SW    = shrb_pkg::SAMPLE_W;
	localparam int CW    = shrb_pkg::CNT_W;
	localparam logic [CW-1:0]    DEPTH_CNT = CW'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_MAX   = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);

	// store: right in the upper half, left in the lower
	logic [2*SW-1:0]  store_q [DEPTH];
	logic [DEPTH-1:0] valid_q;

	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  mark_q;
	logic [PTR_W-1:0]  addr_q;
	logic [CW-1:0]     remain_q;
	logic [shrb_pkg::MODE_W-1:0] mode_q;
	logic [CW-1:0]     fresh_q;

	logic [2*SW-1:0]   rdata_s1;
	logic              vld_s1;
	logic              stb_s1;
	logic              last_s1;
	logic [shrb_pkg::MODE_W-1:0] mode_s1;
	logic [CW-1:0]     fresh_s1;

	logic              done_s2;
	logic [SW-1:0]     left_s2;
	logic [SW-1:0]     right_s2;
	logic [CW-1:0]     fresh_s2;
	logic              last_s2;

	logic [CW-1:0]     count_clamped;
	logic [PTR_W-1:0]  head_prev;
	logic [PTR_W-1:0]  addr_prev;
	logic [PTR_W:0]    fresh_diff;
	logic [CW-1:0]     fresh_raw;
	logic [CW-1:0]     fresh_new;
	logic [2*SW-1:0]   word_s1;

	assign count_clamped = (read_count > DEPTH_CNT) ? DEPTH_CNT : read_count;
	assign head_prev     = (wp_q == '0) ? PTR_MAX : wp_q - 1'b1;
	assign addr_prev     = (addr_q == '0) ? PTR_MAX : addr_q - 1'b1;

	// distance from mark to head, modulo the depth
	always_comb begin
		if (wp_q >= mark_q)
			fresh_diff = {1'b0, wp_q} - {1'b0, mark_q};
		else
			fresh_diff = {1'b0, wp_q} + DEPTH_EXT - {1'b0, mark_q};
		fresh_raw = CW'(fresh_diff);
		if (read_mode == shrb_pkg::MODE_PEEK)
			fresh_new = '0;
		else if (fresh_raw > count_clamped)
			fresh_new = count_clamped;
		else
			fresh_new = fresh_raw;
	end

	assign status.count_zero = (count_clamped == '0);
	assign status.last_issue = (remain_q == CW'(1));

	// store write port
	always_ff @(posedge clk) begin
		if (cmd.write_en)
			store_q[wp_q] <= cmd.mono ? {left_sample, left_sample} : {right_sample, left_sample};
	end

	// store read port
	always_ff @(posedge clk) begin
		if (cmd.issue)
			rdata_s1 <= store_q[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			wp_q     <= '0;
			mark_q   <= '0;
			remain_q <= '0;
		end else begin
			if (cmd.write_en) begin
				valid_q[wp_q] <= 1'b1;
				wp_q          <= (wp_q == PTR_MAX) ? '0 : wp_q + 1'b1;
			end
			if (cmd.read_start) begin
				remain_q <= count_clamped;
				// a zero-length marking read still moves the mark
				if (read_mode != shrb_pkg::MODE_PEEK)
					mark_q <= wp_q;
			end else if (cmd.issue) begin
				remain_q <= remain_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_start) begin
			addr_q  <= head_prev;
			mode_q  <= read_mode;
			fresh_q <= fresh_new;
		end else if (cmd.issue) begin
			addr_q <= addr_prev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stb_s1  <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			stb_s1  <= cmd.issue;
			done_s2 <= stb_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			vld_s1   <= valid_q[addr_q];
			last_s1  <= status.last_issue;
			mode_s1  <= mode_q;
			fresh_s1 <= fresh_q;
		end
	end

	// never-written entries read as zero
	assign word_s1 = vld_s1 ? rdata_s1 : '0;

	always_ff @(posedge clk) begin
		if (stb_s1) begin
			left_s2  <= shrb_pkg::fmt_sample(mode_s1, word_s1[SW-1:0]);
			right_s2 <= shrb_pkg::fmt_sample(mode_s1, word_s1[2*SW-1:SW]);
			fresh_s2 <= fresh_s1;
			last_s2  <= last_s1;
		end
	end

	assign done        = done_s2;
	assign out_left    = left_s2;
	assign out_right   = right_s2;
	assign fresh_count = fresh_s2;
	assign last        = done_s2 && last_s2;

	a_issue_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> ##1 done_s2)
		else $error("read word did not reach the output");

	a_no_write_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.write_en && cmd.issue))
		else $error("store written during a burst");

	a_issue_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> remain_q != '0)
		else $error("issue with nothing left to read");

endmodule

// ===== sv/stereo_history_ring_buffer.sv =====
// Top level of the stereo history ring buffer: controller plus datapath
//
//  channel  | handshake          | fields
//  ---------+--------------------+----------------------------------------------------
//  command  | start / busy       | operation, left_sample, right_sample, read_count,
//           |                    | read_mode
//  result   | done (strobe)      | out_left, out_right, fresh_count, last
//
// A command word is taken at an edge with start high and busy low.
// Writes keep busy low, so they can follow every cycle.
// A read of N words (N clamped to DEPTH) raises busy for N store reads through
// the single read port, then a flush state; results stream one per cycle, each
// word registered at the store read and again at the output stage. A zero-length
// read does not raise busy and returns no result words.
// Reset clears pointers, mark and the per-entry valid bits at once; no clearing pass.
// The receiver cannot stall; done flags each result word for one cycle only.
module stereo_history_ring_buffer #(
	parameter int DEPTH = shrb_pkg::DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [shrb_pkg::OP_W-1:0]            operation,
	input  logic signed [shrb_pkg::SAMPLE_W-1:0] left_sample,
	input  logic signed [shrb_pkg::SAMPLE_W-1:0] right_sample,
	input  logic [shrb_pkg::CNT_W-1:0]           read_count,
	input  logic [shrb_pkg::MODE_W-1:0]          read_mode,
	output logic                                 done,
	output logic signed [shrb_pkg::SAMPLE_W-1:0] out_left,
	output logic signed [shrb_pkg::SAMPLE_W-1:0] out_right,
	output logic [shrb_pkg::CNT_W-1:0]           fresh_count,
	output logic                                 last
);

	shrb_pkg::shrb_cmd_t    cmd;
	shrb_pkg::shrb_status_t status;

	shrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	shrb_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.read_count   (read_count),
		.read_mode    (read_mode),
		.done         (done),
		.out_left     (out_left),
		.out_right    (out_right),
		.fresh_count  (fresh_count),
		.last         (last)
	);

endmodule

// ===== dv/testbench.sv =====
// Testbench for the stereo history ring buffer: write/read traffic checked against a local ring model
`timescale 1ns / 100ps

module testbench;
	import shrb_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int STALL_MAX  = 2000;
	localparam int SETTLE_CYC = 8;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic [CNT_W-1:0]           fresh;
		logic                       last;
	} hist_word_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [OP_W-1:0] operation;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic [CNT_W-1:0] read_count;
	logic [MODE_W-1:0] read_mode;
	logic done;
	logic signed [SAMPLE_W-1:0] out_left;
	logic signed [SAMPLE_W-1:0] out_right;
	logic [CNT_W-1:0] fresh_count;
	logic last;

	// local copy of the history ring
	logic [31:0] hist_ring [DEPTH];
	int wr_head;
	int mark_pos;

	hist_word_t pending_words[$];

	int failures;
	int writes_sent;
	int reads_sent;
	int words_checked;
	int burst_left;
	int gap_max;
	int stall_cycles;

	stereo_history_ring_buffer uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.read_count(read_count),
		.read_mode(read_mode),
		.done(done),
		.out_left(out_left),
		.out_right(out_right),
		.fresh_count(fresh_count),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [SAMPLE_W-1:0] q15_to_s8(logic signed [SAMPLE_W-1:0] s);
		int p;
		int v;
		p = int'(s) * 127;
		v = (p < 0) ? -((-p) >>> 15) : (p >>> 15);
		if (v > 127) v = 127;
		if (v < -128) v = -128;
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] q15_to_u8(logic signed [SAMPLE_W-1:0] s);
		int v;
		// offset keeps the sum positive, so a plain shift truncates toward zero
		v = (128 * 32768 + int'(s) * 127) >>> 15;
		if (v > 255) v = 255;
		if (v < 0) v = 0;
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] format_sample(logic [MODE_W-1:0] mode,
			logic signed [SAMPLE_W-1:0] s);
		case (mode)
			MODE_S8: return q15_to_s8(s);
			MODE_U8: return q15_to_u8(s);
			default: return s;
		endcase
	endfunction

	// apply one accepted command word to the local ring, queue the words it will return
	task automatic apply_to_ring(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] l,
			logic [SAMPLE_W-1:0] r, logic [CNT_W-1:0] cnt, logic [MODE_W-1:0] mode);
		int n;
		int fresh;
		int idx;
		logic [31:0] entry;
		hist_word_t w;
		case (op)
			OP_WRITE_STEREO, OP_WRITE_MONO: begin
				hist_ring[PTR_W'(wr_head)] = (op == OP_WRITE_MONO) ? {l, l} : {r, l};
				wr_head = (wr_head + 1) % DEPTH;
				writes_sent++;
			end
			OP_READ: begin
				n = (cnt > DEPTH) ? DEPTH : int'(cnt);
				if (mode == MODE_PEEK) begin
					fresh = 0;
				end else begin
					fresh = (wr_head + DEPTH - mark_pos) % DEPTH;
					if (fresh > n) fresh = n;
					mark_pos = wr_head;
				end
				idx = wr_head;
				for (int k = 0; k < n; k++) begin
					idx = (idx + DEPTH - 1) % DEPTH;
					entry = hist_ring[PTR_W'(idx)];
					w.left  = format_sample(mode, entry[15:0]);
					w.right = format_sample(mode, entry[31:16]);
					w.fresh = fresh[CNT_W-1:0];
					w.last  = (k + 1 == n);
					pending_words.push_back(w);
				end
				reads_sent++;
			end
			default: ;
		endcase
	endtask

	// drive one command word and hold it until the block takes it
	task automatic send_word(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] l,
			logic [SAMPLE_W-1:0] r, logic [CNT_W-1:0] cnt, logic [MODE_W-1:0] mode);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        <= 1'b1;
		operation    <= op;
		left_sample  <= l;
		right_sample <= r;
		read_count   <= cnt;
		read_mode    <= mode;
		do @(posedge clk); while (busy);
		apply_to_ring(op, l, r, cnt, mode);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		// a zero-length read may still be in flight
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'hffff;
			3: return 16'h0000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] rand_count();
		case ($urandom_range(0, 15))
			0: return '0;
			1, 2: return CNT_W'($urandom_range(17, 64));
			3: return CNT_W'($urandom_range(65, 127));
			default: return CNT_W'($urandom_range(1, 16));
		endcase
	endfunction

	task automatic send_write(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] l,
			logic [SAMPLE_W-1:0] r);
		send_word(op, l, r, CNT_W'($urandom), MODE_W'($urandom));
	endtask

	task automatic send_read(logic [CNT_W-1:0] cnt, logic [MODE_W-1:0] mode);
		send_word(OP_READ, SAMPLE_W'($urandom), SAMPLE_W'($urandom), cnt, mode);
	endtask

	task automatic test_cleared_store();
		send_read(7'd64, MODE_Q15);
		wait_drained();
	endtask

	task automatic test_extremes();
		send_write(OP_WRITE_STEREO, 16'h8000, 16'h7fff);
		send_write(OP_WRITE_STEREO, 16'h7fff, 16'h8000);
		send_write(OP_WRITE_MONO, 16'h8000, SAMPLE_W'($urandom));
		send_write(OP_WRITE_MONO, 16'h7fff, SAMPLE_W'($urandom));
		send_write(OP_WRITE_STEREO, 16'h0000, 16'hffff);
		send_write(OP_WRITE_STEREO, 16'h0001, 16'hfffe);
		send_write(OP_WRITE_STEREO, 16'h0102, 16'hfefe);
		send_read(7'd7, MODE_Q15);
		send_read(7'd7, MODE_S8);
		send_read(7'd7, MODE_U8);
		send_read(7'd7, MODE_PEEK);
		send_word(OP_UNUSED, SAMPLE_W'($urandom), SAMPLE_W'($urandom), CNT_W'($urandom),
			MODE_W'($urandom));
		send_read(7'd127, MODE_PEEK);
		send_write(OP_WRITE_MONO, 16'h4000, SAMPLE_W'($urandom));
		send_read(7'd0, MODE_S8);     // zero length still moves the mark
		send_write(OP_WRITE_STEREO, 16'hc000, 16'h3fff);
		send_write(OP_WRITE_STEREO, 16'h00ff, 16'hff01);
		send_read(7'd65, MODE_S8);
		send_read(7'd3, MODE_U8);
		wait_drained();
	endtask

	task automatic test_full_wrap();
		repeat (DEPTH) send_write(OP_WRITE_STEREO, rand_sample(), rand_sample());
		send_read(7'd1, MODE_Q15);    // exactly one lap: nothing reported fresh
		repeat (DEPTH - 1) send_write(OP_WRITE_MONO, rand_sample(), SAMPLE_W'($urandom));
		send_read(7'd64, MODE_U8);
		send_read(7'd100, MODE_Q15);
		wait_drained();
	endtask

	task automatic test_random_traffic(int n_items);
		int sent;
		int n_wr;
		sent = 0;
		while (sent < n_items) begin
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			case ($urandom_range(0, 19))
				0: begin
					send_word(OP_UNUSED, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
						CNT_W'($urandom), MODE_W'($urandom));
				end
				1, 2: begin
					send_read(rand_count(), MODE_W'($urandom));
					sent++;
				end
				default: begin
					n_wr = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70)
						: $urandom_range(0, 8);
					repeat (n_wr) begin
						send_write(OP_W'($urandom_range(0, 1)), rand_sample(),
							rand_sample());
						sent++;
					end
					send_read(rand_count(), MODE_W'($urandom));
					sent++;
				end
			endcase
			if ($urandom_range(0, 29) == 0) wait_drained();
		end
		gap_max = 8;
		wait_drained();
	endtask

	always @(posedge clk) begin
		hist_word_t w;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result word: left %0d right %0d", out_left, out_right);
				failures++;
			end else begin
				w = pending_words.pop_front();
				if (out_left !== w.left) begin
					$error("out_left: expected %0d, got %0d", w.left, out_left);
					failures++;
				end
				if (out_right !== w.right) begin
					$error("out_right: expected %0d, got %0d", w.right, out_right);
					failures++;
				end
				if (fresh_count !== w.fresh) begin
					$error("fresh_count: expected %0d, got %0d", w.fresh, fresh_count);
					failures++;
				end
				if (last !== w.last) begin
					$error("last: expected %0b, got %0b", w.last, last);
					failures++;
				end
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_MAX) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int settle;
		failures      = 0;
		writes_sent   = 0;
		reads_sent    = 0;
		words_checked = 0;
		burst_left    = 0;
		gap_max       = 8;
		stall_cycles  = 0;
		wr_head       = 0;
		mark_pos      = 0;
		foreach (hist_ring[i]) hist_ring[i] = '0;
		arst_n       = 1'b0;
		start        = 1'b0;
		operation    = OP_WRITE_STEREO;
		left_sample  = '0;
		right_sample = '0;
		read_count   = '0;
		read_mode    = MODE_Q15;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_cleared_store();
		test_extremes();
		test_full_wrap();
		test_random_traffic(300);

		@(negedge clk);
		start <= 1'b0;
		settle = 0;
		while (pending_words.size() != 0 && settle < 5000) begin
			@(posedge clk);
			settle++;
		end
		repeat (SETTLE_CYC) @(posedge clk);
		if (pending_words.size() != 0) begin
			$error("%0d result words never arrived", pending_words.size());
			failures++;
		end
		$display("Run covered %0d sample writes and %0d read bursts in all four formats,",
			writes_sent, reads_sent);
		$display("including wrap, oversize and zero-length reads; %0d result words checked.",
			words_checked);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
